/* hw/rtl/mp3fd_pkg.sv */
package mp3fd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR3,
        PH_HDR4,
        PH_BODY,
        PH_END
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_DIV,
        SQ_CHECK,
        SQ_HDR
    } seq_t;

    typedef enum logic [1:0] {
        CFG_BIT_RATE      = 2'd0,
        CFG_SAMPLE_RATE   = 2'd1,
        CFG_FRAME_SAMPLES = 2'd2,
        CFG_STREAM_BYTES  = 2'd3
    } cfg_idx_t;

    localparam int BIT_RATE_W   = 19;
    localparam int RATE_W       = 16;
    localparam int FSAMP_W      = 11;
    localparam int COUNT_W      = 32;
    localparam int BODY_W       = 14;
    localparam int PTS_OUT_W    = 48;

    // 144 * bit_rate = (bit_rate << 7) + (bit_rate << 4)
    localparam int MUL_SH_HI    = 7;
    localparam int MUL_SH_LO    = 4;
    localparam int DIVIDEND_W   = 27;
    localparam int DIVISOR_W    = RATE_W;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
    localparam int SIZE_W       = DIVIDEND_W + 1;

    localparam logic [15:0] SYNC_MASK = 16'hFFE0;
    localparam int          PAD_BIT   = 9;
    localparam logic [BODY_W-1:0] BODY_MAX = '1;
    localparam logic [SIZE_W-1:0] HDR_BYTES = SIZE_W'(4);

    localparam logic [BIT_RATE_W-1:0] BIT_RATE_RST = BIT_RATE_W'(128000);
    localparam logic [RATE_W-1:0]     RATE_RST     = RATE_W'(44100);
    localparam logic [FSAMP_W-1:0]    FSAMP_RST    = FSAMP_W'(1152);

endpackage

/* hw/rtl/mp3fd_div.sv */
module mp3fd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mp3fd_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [mp3fd_pkg::DIVISOR_W-1:0]     divisor,
    output logic                                done,
    output logic [mp3fd_pkg::DIVIDEND_W-1:0]    quotient
);

    logic [mp3fd_pkg::DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [mp3fd_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [mp3fd_pkg::DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [mp3fd_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [mp3fd_pkg::DIVISOR_W:0]    trial;
    logic [mp3fd_pkg::DIVISOR_W:0]    diff;
    logic                             ge;

    // one restoring step per cycle, quotient bits shift in as dividend shifts out
    assign trial = {rem_reg, quo_reg[mp3fd_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = mp3fd_pkg::DIV_CNT_W'(mp3fd_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[mp3fd_pkg::DIVISOR_W-1:0] : trial[mp3fd_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[mp3fd_pkg::DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mp3fd_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/mp3_frame_deframer.sv */
// A body byte, or an end-of-stream beat from a taken byte, shows on m_* in the cycle
// after that byte is taken. The fourth header byte starts a divider run for the frame
// size; the size check and four header beats follow, one beat per cycle unless the
// output stalls. Bytes are taken one per cycle while hunting or in a body, unless the
// output stalls; the last header byte holds input until the check and header beats end.
// Reset: hunting, empty stream, config at default rates.
module mp3_frame_deframer #(
    parameter int PTS_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] out_byte, [55:8] frame_pts
    output logic        m_tlast,   // frame_end
    output logic [2:0]  m_tuser,   // [0] frame_start, [1] end_of_stream, [2] run_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int PW = mp3fd_pkg::PTS_OUT_W;

    mp3fd_pkg::phase_t phase_reg, phase_next;
    mp3fd_pkg::seq_t   seq_reg, seq_next;

    logic [mp3fd_pkg::BIT_RATE_W-1:0] bit_rate_reg, bit_rate_next;
    logic [mp3fd_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic [mp3fd_pkg::FSAMP_W-1:0]    fsamp_reg, fsamp_next;
    logic [mp3fd_pkg::COUNT_W-1:0]    left_reg, left_next;
    logic [mp3fd_pkg::BODY_W-1:0]     frame_reg, frame_next;
    logic [31:0]                      hold_reg, hold_next;
    logic [PTS_BITS-1:0]              pts_reg, pts_next;
    logic [mp3fd_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [1:0]                       idx_reg, idx_next;

    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic          ostart_reg, ostart_next;
    logic          oend_reg, oend_next;
    logic [PW-1:0] opts_reg, opts_next;
    logic          oeos_reg, oeos_next;
    logic          olast_reg, olast_next;

    logic                              out_free;
    logic                              in_acc;
    logic                              cfg_acc;
    logic [31:0]                       hold_shift;
    logic [mp3fd_pkg::COUNT_W-1:0]     left_dec;
    logic                              left_zero;
    logic                              sync_hit;
    logic                              div_start;
    logic                              div_done;
    logic [mp3fd_pkg::DIVIDEND_W-1:0]  dividend;
    logic [mp3fd_pkg::DIVIDEND_W-1:0]  quotient;
    logic [mp3fd_pkg::SIZE_W-1:0]      size_clamp;
    logic [mp3fd_pkg::SIZE_W-1:0]      body_full;
    logic                              too_big;
    logic [PTS_BITS+PW-1:0]            pts_wide;
    logic [PW-1:0]                     pts_cur;
    logic [7:0]                        hdr_byte;

    assign out_free   = !ov_reg || m_tready;
    assign s_tready   = (seq_reg == mp3fd_pkg::SQ_IDLE) && out_free;
    assign cfg_ready  = 1'b1;
    assign in_acc     = s_tvalid && s_tready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign hold_shift = {hold_reg[23:0], s_tdata};
    assign left_dec   = left_reg - 1'b1;
    assign left_zero  = left_reg == '0;
    assign sync_hit   = (hold_shift[15:0] & mp3fd_pkg::SYNC_MASK) == mp3fd_pkg::SYNC_MASK;
    assign pts_wide   = {PW'(0), pts_reg};
    assign pts_cur    = pts_wide[PW-1:0];
    assign hdr_byte   = hold_reg[{~idx_reg, 3'b000} +: 8];

    assign dividend = (mp3fd_pkg::DIVIDEND_W'(bit_rate_reg) << mp3fd_pkg::MUL_SH_HI)
                    + (mp3fd_pkg::DIVIDEND_W'(bit_rate_reg) << mp3fd_pkg::MUL_SH_LO);
    assign div_start = in_acc && (phase_reg == mp3fd_pkg::PH_HDR4) && !left_zero
                    && (rate_reg != '0);

    assign size_clamp = (size_reg < mp3fd_pkg::HDR_BYTES) ? mp3fd_pkg::HDR_BYTES : size_reg;
    assign body_full  = size_clamp - mp3fd_pkg::HDR_BYTES;
    assign too_big    = ({5'b0, size_clamp} > ({1'b0, left_reg} + 33'd4))
                     || (body_full > mp3fd_pkg::SIZE_W'(mp3fd_pkg::BODY_MAX));

    mp3fd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            mp3fd_pkg::SQ_IDLE:
                if (div_start)
                    seq_next = mp3fd_pkg::SQ_DIV;
            mp3fd_pkg::SQ_DIV:
                if (div_done)
                    seq_next = mp3fd_pkg::SQ_CHECK;
            mp3fd_pkg::SQ_CHECK:
                if (out_free)
                    seq_next = too_big ? mp3fd_pkg::SQ_IDLE : mp3fd_pkg::SQ_HDR;
            mp3fd_pkg::SQ_HDR:
                if (out_free && idx_reg == 2'd3)
                    seq_next = mp3fd_pkg::SQ_IDLE;
            default:
                seq_next = mp3fd_pkg::SQ_IDLE;
        endcase
    end

    always_comb
    begin
        logic do_eos;
        logic do_next_frame;
        do_eos        = 1'b0;
        do_next_frame = 1'b0;

        phase_next    = phase_reg;
        bit_rate_next = bit_rate_reg;
        rate_next     = rate_reg;
        fsamp_next    = fsamp_reg;
        left_next     = left_reg;
        frame_next    = frame_reg;
        hold_next     = hold_reg;
        pts_next      = pts_reg;
        size_next     = size_reg;
        idx_next      = idx_reg;

        ov_next     = ov_reg && !m_tready;
        ob_next     = ob_reg;
        ostart_next = ostart_reg;
        oend_next   = oend_reg;
        opts_next   = opts_reg;
        oeos_next   = oeos_reg;
        olast_next  = olast_reg;

        unique case (seq_reg)
            mp3fd_pkg::SQ_IDLE:
                if (in_acc)
                begin
                    unique case (phase_reg)
                        mp3fd_pkg::PH_HUNT:
                            if (left_zero)
                                do_eos = 1'b1;
                            else
                            begin
                                left_next = left_dec;
                                hold_next = hold_shift;
                                if (sync_hit)
                                begin
                                    if (left_dec <= mp3fd_pkg::COUNT_W'(2))
                                        do_eos = 1'b1;
                                    else
                                        phase_next = mp3fd_pkg::PH_HDR3;
                                end
                                else if (left_dec == '0)
                                    do_eos = 1'b1;
                            end
                        mp3fd_pkg::PH_HDR3:
                            if (left_zero)
                                do_eos = 1'b1;
                            else
                            begin
                                left_next  = left_dec;
                                hold_next  = hold_shift;
                                phase_next = mp3fd_pkg::PH_HDR4;
                            end
                        mp3fd_pkg::PH_HDR4:
                            if (left_zero)
                                do_eos = 1'b1;
                            else
                            begin
                                left_next = left_dec;
                                hold_next = hold_shift;
                                if (rate_reg == '0)
                                    do_eos = 1'b1;
                            end
                        mp3fd_pkg::PH_BODY:
                            if (left_zero || frame_reg == '0)
                                do_eos = 1'b1;
                            else
                            begin
                                left_next   = left_dec;
                                frame_next  = frame_reg - 1'b1;
                                ov_next     = 1'b1;
                                ob_next     = s_tdata;
                                ostart_next = 1'b0;
                                oend_next   = frame_reg == mp3fd_pkg::BODY_W'(1);
                                opts_next   = pts_cur;
                                oeos_next   = 1'b0;
                                olast_next  = 1'b1;
                                if (frame_reg == mp3fd_pkg::BODY_W'(1))
                                    do_next_frame = 1'b1;
                            end
                        default:
                            ;
                    endcase
                end
            mp3fd_pkg::SQ_DIV:
                if (div_done)
                    size_next = {1'b0, quotient} + mp3fd_pkg::SIZE_W'(hold_reg[mp3fd_pkg::PAD_BIT]);
            mp3fd_pkg::SQ_CHECK:
                if (out_free)
                begin
                    if (too_big)
                        do_eos = 1'b1;
                    else
                    begin
                        frame_next = body_full[mp3fd_pkg::BODY_W-1:0];
                        idx_next   = 2'd0;
                    end
                end
            mp3fd_pkg::SQ_HDR:
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    ob_next     = hdr_byte;
                    ostart_next = idx_reg == 2'd0;
                    oend_next   = (idx_reg == 2'd3) && (frame_reg == '0);
                    opts_next   = pts_cur;
                    oeos_next   = 1'b0;
                    olast_next  = idx_reg == 2'd3;
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        if (frame_reg == '0)
                            do_next_frame = 1'b1;
                        else
                            phase_next = mp3fd_pkg::PH_BODY;
                    end
                end
            default:
                ;
        endcase

        if (do_eos)
        begin
            phase_next  = mp3fd_pkg::PH_END;
            ov_next     = 1'b1;
            ob_next     = '0;
            ostart_next = 1'b0;
            oend_next   = 1'b0;
            opts_next   = pts_cur;
            oeos_next   = 1'b1;
            olast_next  = 1'b1;
        end

        if (do_next_frame)
        begin
            pts_next   = pts_reg + PTS_BITS'(fsamp_reg);
            hold_next  = '0;
            frame_next = '0;
            phase_next = mp3fd_pkg::PH_HUNT;
        end

        if (cfg_acc)
        begin
            unique case (mp3fd_pkg::cfg_idx_t'(cfg_index))
                mp3fd_pkg::CFG_BIT_RATE:
                    bit_rate_next = cfg_data[mp3fd_pkg::BIT_RATE_W-1:0];
                mp3fd_pkg::CFG_SAMPLE_RATE:
                    rate_next = cfg_data[mp3fd_pkg::RATE_W-1:0];
                mp3fd_pkg::CFG_FRAME_SAMPLES:
                    fsamp_next = cfg_data[mp3fd_pkg::FSAMP_W-1:0];
                mp3fd_pkg::CFG_STREAM_BYTES:
                begin
                    phase_next = mp3fd_pkg::PH_HUNT;
                    hold_next  = '0;
                    left_next  = cfg_data;
                    frame_next = '0;
                    pts_next   = '0;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mp3fd_pkg::PH_HUNT;
            seq_reg      <= mp3fd_pkg::SQ_IDLE;
            bit_rate_reg <= mp3fd_pkg::BIT_RATE_RST;
            rate_reg     <= mp3fd_pkg::RATE_RST;
            fsamp_reg    <= mp3fd_pkg::FSAMP_RST;
            left_reg     <= '0;
            frame_reg    <= '0;
            hold_reg     <= '0;
            pts_reg      <= '0;
            idx_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            bit_rate_reg <= bit_rate_next;
            rate_reg     <= rate_next;
            fsamp_reg    <= fsamp_next;
            left_reg     <= left_next;
            frame_reg    <= frame_next;
            hold_reg     <= hold_next;
            pts_reg      <= pts_next;
            idx_reg      <= idx_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        ob_reg     <= ob_next;
        ostart_reg <= ostart_next;
        oend_reg   <= oend_next;
        opts_reg   <= opts_next;
        oeos_reg   <= oeos_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {opts_reg, ob_reg};
    assign m_tlast  = oend_reg;
    assign m_tuser  = {olast_reg, oeos_reg, ostart_reg};

    a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[2])
        else $error("frame start beat marked as last of run");

    a_eos_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[2] && !m_tlast && !m_tuser[0]))
        else $error("end of stream beat malformed");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mp3fd_pkg::PH_END && !cfg_acc) |=> phase_reg == mp3fd_pkg::PH_END)
        else $error("left end state without restart");

    a_div_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> seq_reg == mp3fd_pkg::SQ_DIV)
        else $error("divider finished outside of size step");

    a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mp3fd_pkg::PH_BODY) |-> frame_reg != '0)
        else $error("body phase with empty frame count");

endmodule

/* tb/mp3fd_checker.sv */
`timescale 1ns / 1ps

module mp3fd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [7:0] out_byte, [55:8] frame_pts
    input  logic        m_tlast,   // frame_end
    input  logic [2:0]  m_tuser,   // [0] frame_start, [1] end_of_stream, [2] run_last
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          pending,
    output int          errors
);

    typedef struct packed {
        logic [7:0]                      data;
        logic                            first;
        logic                            frame_end;
        logic [mp3fd_pkg::PTS_OUT_W-1:0] pts;
        logic                            eos;
        logic                            run_end;
    } beat_t;

    logic [mp3fd_pkg::BIT_RATE_W-1:0] bit_rate_r;
    logic [mp3fd_pkg::RATE_W-1:0]     rate_r;
    logic [mp3fd_pkg::FSAMP_W-1:0]    fsamp_r;
    logic [mp3fd_pkg::COUNT_W-1:0]    stream_len_r;

    mp3fd_pkg::phase_t                ph;
    logic [31:0]                      hdr_shift;
    logic [mp3fd_pkg::COUNT_W-1:0]    stream_left;
    logic [mp3fd_pkg::COUNT_W-1:0]    frame_left;
    logic [mp3fd_pkg::PTS_OUT_W-1:0]  pts_now;

    beat_t                            beat_q[$];

    function automatic string fmt_beat(input beat_t x);
        return $sformatf("byte=%02h start=%0b end=%0b pts=%0d eos=%0b last=%0b",
                         x.data, x.first, x.frame_end, x.pts, x.eos, x.run_end);
    endfunction

    task automatic push_beat(input logic [7:0] d, input logic st, input logic fe,
                             input logic eos, input logic rl);
        beat_q.push_back(beat_t'{d, st, fe, pts_now, eos, rl});
    endtask

    task automatic end_stream();
        ph = mp3fd_pkg::PH_END;
        push_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic close_frame();
        pts_now    = pts_now + mp3fd_pkg::PTS_OUT_W'(fsamp_r);
        hdr_shift  = '0;
        frame_left = '0;
        ph         = mp3fd_pkg::PH_HUNT;
    endtask

    task automatic restart_stream();
        ph          = mp3fd_pkg::PH_HUNT;
        hdr_shift   = '0;
        stream_left = stream_len_r;
        frame_left  = '0;
        pts_now     = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        longint unsigned size;
        int              i;
        case (ph)
            mp3fd_pkg::PH_HUNT:
            begin
                if (stream_left == 0)
                    end_stream();
                else
                begin
                    stream_left--;
                    hdr_shift = {hdr_shift[23:0], b};
                    if ((hdr_shift[15:0] & mp3fd_pkg::SYNC_MASK) == mp3fd_pkg::SYNC_MASK)
                    begin
                        if (stream_left <= 2)
                            end_stream();
                        else
                            ph = mp3fd_pkg::PH_HDR3;
                    end
                    else if (stream_left == 0)
                        end_stream();
                end
            end
            mp3fd_pkg::PH_HDR3:
            begin
                if (stream_left == 0)
                    end_stream();
                else
                begin
                    stream_left--;
                    hdr_shift = {hdr_shift[23:0], b};
                    ph        = mp3fd_pkg::PH_HDR4;
                end
            end
            mp3fd_pkg::PH_HDR4:
            begin
                if (stream_left == 0)
                    end_stream();
                else
                begin
                    stream_left--;
                    hdr_shift = {hdr_shift[23:0], b};
                    if (rate_r == 0)
                        end_stream();
                    else
                    begin
                        size = (64'd144 * bit_rate_r) / rate_r
                             + hdr_shift[mp3fd_pkg::PAD_BIT];
                        if (size < 4)
                            size = 4;
                        if (size > {32'd0, stream_left} + 64'd4
                            || size - 4 > mp3fd_pkg::BODY_MAX)
                            end_stream();
                        else
                        begin
                            for (i = 0; i < 4; i++)
                                push_beat(hdr_shift[31 - 8 * i -: 8], i == 0,
                                          i == 3 && size == 4, 1'b0, i == 3);
                            if (size == 4)
                                close_frame();
                            else
                            begin
                                frame_left = mp3fd_pkg::COUNT_W'(size - 4);
                                ph         = mp3fd_pkg::PH_BODY;
                            end
                        end
                    end
                end
            end
            mp3fd_pkg::PH_BODY:
            begin
                if (stream_left == 0 || frame_left == 0)
                    end_stream();
                else
                begin
                    stream_left--;
                    frame_left--;
                    push_beat(b, 1'b0, frame_left == 0, 1'b0, 1'b1);
                    if (frame_left == 0)
                        close_frame();
                end
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t want, got;
        if (!rst_n)
        begin
            bit_rate_r   = mp3fd_pkg::BIT_RATE_RST;
            rate_r       = mp3fd_pkg::RATE_RST;
            fsamp_r      = mp3fd_pkg::FSAMP_RST;
            stream_len_r = '0;
            restart_stream();
            beat_q.delete();
            errors       = 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mp3fd_pkg::CFG_BIT_RATE:
                        bit_rate_r = cfg_data[mp3fd_pkg::BIT_RATE_W-1:0];
                    mp3fd_pkg::CFG_SAMPLE_RATE:
                        rate_r     = cfg_data[mp3fd_pkg::RATE_W-1:0];
                    mp3fd_pkg::CFG_FRAME_SAMPLES:
                        fsamp_r    = cfg_data[mp3fd_pkg::FSAMP_W-1:0];
                    mp3fd_pkg::CFG_STREAM_BYTES:
                    begin
                        stream_len_r = cfg_data;
                        restart_stream();
                    end
                    default:
                        ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = beat_t'{m_tdata[7:0], m_tuser[0], m_tlast, m_tdata[55:8],
                              m_tuser[1], m_tuser[2]};
                if (beat_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t unexpected beat: %s", $realtime, fmt_beat(got));
                end
                else
                begin
                    want = beat_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t beat mismatch\n  expected %s\n  actual   %s",
                                     $realtime, fmt_beat(want), fmt_beat(got));
                    end
                end
            end
            pending <= beat_q.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int RAND_BYTES    = 260;
    localparam int SETTLE_CYCLES = 48;

    typedef enum logic [1:0] {
        TAIL_EXACT,
        TAIL_CUT,
        TAIL_SLACK,
        TAIL_SYNC
    } tail_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic                  m_tlast;
    logic [2:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    mp3fd_pkg::cfg_idx_t   cfg_index = mp3fd_pkg::CFG_BIT_RATE;
    logic [31:0]           cfg_data  = '0;
    int                    pending;
    int                    errors;

    bit          idle_on   = 1'b0;
    int          rx_hold   = 0;
    int unsigned br, sr, fs;
    logic [7:0]  stream_q[$];

    mp3_frame_deframer i_dut (.*);

    mp3fd_checker i_chk (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 16);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input mp3fd_pkg::cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending, wait out every expected beat and the header divider
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_noise(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                stream_q.push_back(8'hFF);
                stream_q.push_back(8'($urandom_range(0, 8'hDF)));
            end
            else
                stream_q.push_back(8'($urandom_range(0, 8'hFE)));
        end
    endtask

    task automatic add_frame(input bit pad);
        longint unsigned size;
        size = (sr == 0) ? 4 : 64'd144 * br / sr + pad;
        if (size < 4)
            size = 4;
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'hE0 | 8'($urandom_range(0, 31)));
        stream_q.push_back({6'($urandom), pad, 1'($urandom)});
        stream_q.push_back(8'($urandom));
        repeat (size - 4)
            stream_q.push_back(8'($urandom));
        if (size > 4 && $urandom_range(0, 3) == 0)
            stream_q[$] = 8'hFF;
    endtask

    task automatic play_stream(input logic [31:0] sb, input int pause_at);
        write_reg(mp3fd_pkg::CFG_BIT_RATE, br);
        write_reg(mp3fd_pkg::CFG_SAMPLE_RATE, sr);
        write_reg(mp3fd_pkg::CFG_FRAME_SAMPLES, fs);
        write_reg(mp3fd_pkg::CFG_STREAM_BYTES, sb);
        cfg_valid <= 1'b0;
        foreach (stream_q[i])
        begin
            send_byte(stream_q[i]);
            if (i == pause_at)
                settle();
        end
        settle();
    endtask

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned total, sb, tgt;
        int          rand_bytes, n_phase, pause_at;
        tail_t       tail;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream after reset: ends at once, then ignores bytes
        idle_on = 1'b1;
        send_byte(8'hA5);
        send_byte(8'h00);
        settle();

        // two header-only frames, second one padded, then end with no count left
        br = 1000;
        sr = 48000;
        fs = 2047;
        stream_q = '{8'hFF, 8'hE1, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h02, 8'h55, 8'h5A};
        play_stream(32'd9, -1);

        // body ends in FF; next E0 must not sync, last count ends the hunt
        br = 2667;
        fs = 384;
        stream_q = '{8'hFF, 8'hE0, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'hFF, 8'hE0};
        play_stream(32'd9, -1);

        // sync too close to the end
        br = 1000;
        fs = 1152;
        stream_q = '{8'hFF, 8'hE0, 8'h7F};
        play_stream(32'd3, -1);

        // zero sample rate
        br = 8000;
        sr = 0;
        fs = 0;
        stream_q = '{8'hFF, 8'hE0, 8'h00, 8'h00};
        play_stream(32'd10, -1);

        // body far beyond the counter
        br = 524287;
        sr = 1;
        fs = 1;
        stream_q = '{8'hFF, 8'hFF, 8'h80, 8'h00};
        play_stream(32'hFFFF_FFFF, -1);

        rand_bytes = 0;
        n_phase    = 0;
        while (rand_bytes < RAND_BYTES)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            sr      = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(8000, 48000);
            fs      = $urandom_range(384, 1152);
            tgt     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 40);
            br      = tgt * sr / 144 + $urandom_range(0, sr / 144);
            stream_q.delete();
            repeat ($urandom_range(1, 5))
            begin
                add_noise($urandom_range(0, 2));
                add_frame($urandom_range(0, 1));
            end
            total = stream_q.size();
            tail  = tail_t'($urandom_range(0, 3));
            case (tail)
                TAIL_EXACT: sb = total;
                TAIL_CUT:   sb = total - $urandom_range(1, (total < 6) ? total : 6);
                TAIL_SLACK: sb = total + $urandom_range(1, 4);
                TAIL_SYNC:
                begin
                    sb = total + $urandom_range(1, 6);
                    stream_q.push_back(8'hFF);
                    stream_q.push_back(8'hE0 | 8'($urandom_range(0, 31)));
                end
            endcase
            add_noise(5);
            pause_at = (n_phase == 0 || $urandom_range(0, 2) == 0) ?
                       $urandom_range(0, total - 1) : -1;
            play_stream(sb, pause_at);
            rand_bytes += total + 1;
            n_phase++;
        end

        // largest body the counter holds, stopped after a few body bytes
        idle_on = 1'b0;
        br = 16387;
        sr = 144;
        fs = 1152;
        stream_q = '{8'hFF, 8'hF5, 8'h00, 8'h3C, 8'h12, 8'h34, 8'h56, 8'h78};
        play_stream(32'hFFFF_FFFF, -1);

        // padding makes the body one byte too many for the counter
        stream_q = '{8'hFF, 8'hF5, 8'h02, 8'h3C, 8'h00, 8'hFF};
        play_stream(32'hFFFF_FFFF, -1);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* mp3_frame_deframer.f */
hw/rtl/mp3fd_pkg.sv
hw/rtl/mp3fd_div.sv
hw/rtl/mp3_frame_deframer.sv
tb/mp3fd_checker.sv
tb/tb.sv
